### rtl/sstf_request_scheduler_macros.svh
// assertion macros for the sstf request scheduler
// used by the top level; no other dependencies
`ifndef SSTF_REQUEST_SCHEDULER_MACROS_SVH
`define SSTF_REQUEST_SCHEDULER_MACROS_SVH

// same-cycle implication
`define SSTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sstf_pkg.sv
// package for the sstf request scheduler: defaults, types and helpers
// no dependencies
package sstf_pkg;

    localparam int unsigned DEPTH_DEF     = 8;
    localparam int unsigned CYLINDERS_DEF = 256;
    localparam int unsigned CYL_W         = 8;
    localparam int unsigned OUT_SLOT_W    = 3;
    localparam logic [CYL_W-1:0] START_RESET = 8'd13;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] seek;
    } best_t;

    // saturate a cylinder number to the last cylinder of the disk
    function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] v,
                                                   input int unsigned cylinders);
        logic [CYL_W-1:0] r;
        if (32'(v) >= cylinders)
        begin
            r = CYL_W'(cylinders - 1);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/sstf_if.sv
// request and response channel interfaces of the sstf request scheduler
// depends on sstf_pkg
interface sstf_req_if;
    logic                     valid;
    logic                     ready;
    logic [sstf_pkg::CYL_W-1:0] request_cylinder;

    modport source (output valid, output request_cylinder, input ready);
    modport sink (input valid, input request_cylinder, output ready);
endinterface

interface sstf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sstf_pkg::CYL_W-1:0]      served_cylinder;
    logic [sstf_pkg::CYL_W-1:0]      seek_distance;
    logic [sstf_pkg::OUT_SLOT_W-1:0] served_slot;

    modport source (output valid, output served_cylinder, output seek_distance,
                    output served_slot, input ready);
    modport sink (input valid, input served_cylinder, input seek_distance,
                  input served_slot, output ready);
endinterface

### rtl/sstf_cell.sv
// one queue slot of the sstf chain: holds a pending cylinder and passes on
// the nearest entry seen so far; depends on sstf_pkg
module sstf_cell #(
    parameter int unsigned SLOT_W = 3,
    parameter int unsigned INDEX  = 0
) (
    input  logic                         clk,
    input  logic [sstf_pkg::CYL_W-1:0]   head,
    input  logic                         wr_en,
    input  logic [sstf_pkg::CYL_W-1:0]   wr_data,
    input  sstf_pkg::best_t              best_in,
    input  logic [SLOT_W-1:0]            slot_in,
    output sstf_pkg::best_t              best_out,
    output logic [SLOT_W-1:0]            slot_out
);
    import sstf_pkg::*;

    logic [CYL_W-1:0]  entry_reg;
    logic [CYL_W-1:0]  seek;
    logic              take;
    best_t             best_reg;
    best_t             best_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    always_comb
    begin
        seek = (entry_reg > head) ? (entry_reg - head) : (head - entry_reg);
        // first cell always takes its own entry, later ones only when strictly nearer
        take = (INDEX == 0) || (seek < best_in.seek);
        if (take)
        begin
            best_next.cyl  = entry_reg;
            best_next.seek = seek;
            slot_next      = SLOT_W'(INDEX);
        end
        else
        begin
            best_next = best_in;
            slot_next = slot_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
        best_reg <= best_next;
        slot_reg <= slot_next;
    end

    assign best_out = best_reg;
    assign slot_out = slot_reg;

endmodule

### rtl/sstf_request_scheduler.sv
// sstf request scheduler: a fill item is written to the next free slot on accept; a
// serving item goes through accept, the nearest-entry wave along the cell chain and
// output register load (held while the last result is not taken); then the next transaction is taken.
// reset clears control, fill count, head and served flag, start cylinder to 13;
// queue entries stay undefined until written, no clearing pass.
// depends on sstf_pkg, sstf_if, sstf_cell and the macros header
`include "sstf_request_scheduler_macros.svh"

module sstf_request_scheduler #(
    parameter int unsigned DEPTH     = sstf_pkg::DEPTH_DEF,
    parameter int unsigned CYLINDERS = sstf_pkg::CYLINDERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sstf_pkg::CYL_W-1:0] cfg_wdata,
    sstf_req_if.sink                   req,
    sstf_rsp_if.source                 rsp
);
    import sstf_pkg::*;

    localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [0:0] {ST_IDLE, ST_SEARCH} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CYL_W-1:0]   start_reg;
    logic [CYL_W-1:0]   head_reg, head_next;
    logic               served_reg, served_next;
    logic [CYL_W-1:0]   pend_reg, pend_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [CYL_W-1:0]   rsp_cyl_reg, rsp_cyl_next;
    logic [CYL_W-1:0]   rsp_dist_reg, rsp_dist_next;
    logic [OUT_SLOT_W-1:0] rsp_slot_reg, rsp_slot_next;

    logic               accept;
    logic               full;
    logic               done;
    logic               fire_out;
    logic [CYL_W-1:0]   req_clamped;
    logic [CYL_W-1:0]   head;
    logic [CYL_W-1:0]   cell_wdata;
    logic [DEPTH-1:0]   cell_we;

    best_t              chain_best [DEPTH];
    logic [SLOT_W-1:0]  chain_slot [DEPTH];

    assign full        = (fill_reg == CNT_W'(DEPTH));
    assign accept      = req.valid && req.ready;
    assign req_clamped = clamp_cyl(req.request_cylinder, CYLINDERS);
    assign head        = served_reg ? head_reg : clamp_cyl(start_reg, CYLINDERS);
    assign done        = (state_reg == ST_SEARCH) && (cnt_reg == CNT_W'(DEPTH));
    assign fire_out    = done && (!rsp_valid_reg || rsp.ready);
    assign cell_wdata  = (state_reg == ST_SEARCH) ? pend_reg : req_clamped;

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.served_cylinder = rsp_cyl_reg;
    assign rsp.seek_distance   = rsp_dist_reg;
    assign rsp.served_slot     = rsp_slot_reg;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            best_t             b_in;
            logic [SLOT_W-1:0] s_in;

            if (k == 0)
            begin : g_first
                assign b_in = '0;
                assign s_in = '0;
            end
            else
            begin : g_next
                assign b_in = chain_best[k-1];
                assign s_in = chain_slot[k-1];
            end

            assign cell_we[k] = (accept && !full && (fill_reg == CNT_W'(k)))
                             || (fire_out && (chain_slot[DEPTH-1] == SLOT_W'(k)));

            sstf_cell #(
                .SLOT_W (SLOT_W),
                .INDEX  (k)
            ) u_cell (
                .clk      (clk),
                .head     (head),
                .wr_en    (cell_we[k]),
                .wr_data  (cell_wdata),
                .best_in  (b_in),
                .slot_in  (s_in),
                .best_out (chain_best[k]),
                .slot_out (chain_slot[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        served_next    = served_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_cyl_next   = rsp_cyl_reg;
        rsp_dist_next  = rsp_dist_reg;
        rsp_slot_next  = rsp_slot_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pend_next  = req_clamped;
                        cnt_next   = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!done)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (fire_out)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_cyl_next   = chain_best[DEPTH-1].cyl;
                    rsp_dist_next  = chain_best[DEPTH-1].seek;
                    rsp_slot_next  = OUT_SLOT_W'(chain_slot[DEPTH-1]);
                    head_next      = chain_best[DEPTH-1].cyl;
                    served_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            start_reg     <= START_RESET;
            head_reg      <= '0;
            served_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            served_reg    <= served_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        rsp_cyl_reg  <= rsp_cyl_next;
        rsp_dist_reg <= rsp_dist_next;
        rsp_slot_reg <= rsp_slot_next;
    end

    // results only once the queue is full
    `SSTF_ASSERT_NOW(a_rsp_needs_full, clk, rst_n, rsp_valid_reg, full, "result while queue filling")
    // a service moves the head to the served cylinder
    `SSTF_ASSERT_NEXT(a_head_follows, clk, rst_n, fire_out, served_reg && (head_reg == rsp_cyl_reg), "head not moved to served cylinder")
    // search never starts before the queue is full
    `SSTF_ASSERT_NEXT(a_search_full, clk, rst_n, accept && !full, state_reg == ST_IDLE, "search entered while filling")

endmodule
